[sv/slm_pkg.sv]
// Shared constants and types for the stereo level meter.
package slm_pkg;

  localparam int MAX_BLOCK_FRAMES = 256;
  localparam int RMS_WINDOW       = 1024;
  localparam int FS_KHZ           = 44;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;
  localparam int SUMSQ_W  = 39;
  localparam int ACC_W    = 41;
  localparam int FCNT_W   = 9;
  localparam int RCNT_W   = 11;
  localparam int HCNT_W   = 22;
  localparam int DIVD_W   = 41;
  localparam int DIVS_W   = 11;
  localparam int CFG_IDX_W = 8;

  localparam logic [HCNT_W-1:0] HOLD_CNT_MAX = {HCNT_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_THR = 8'd1;

  localparam logic [15:0] HOLD_MS_RESET  = 16'd2000;
  localparam logic [15:0] CLIP_THR_RESET = 16'd32000;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_ctrl_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_stat_t;

endpackage

[sv/slm_divider.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
module slm_divider import slm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  div_ctrl_t ctrl_i,
  output div_stat_t stat_o
);

  logic [DIVD_W-1:0] quo_q;
  logic [DIVS_W-1:0] rem_q;
  logic [DIVS_W-1:0] dvs_q;
  logic [5:0]        cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DIVS_W:0]   shifted;
  logic [DIVS_W:0]   diff;
  logic              ge;

  assign shifted = {rem_q, quo_q[DIVD_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(DIVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      quo_q <= ctrl_i.dividend;
      rem_q <= '0;
      dvs_q <= ctrl_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVD_W-2:0], ge};
      rem_q <= ge ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
    end
  end

  assign stat_o.done     = done_q;
  assign stat_o.quotient = quo_q;

endmodule

[sv/stereo_level_meter_unit.sv]
// Stereo peak / hold / RMS level meter, top level.
//
// Input stream: one stereo frame per beat. tdata carries left_sample in
// bits 15:0 and right_sample in 31:16, tlast marks the last frame of a
// block, tuser carries clear_levels. A block also ends on its 256th frame.
// Output stream: one result beat per input frame with the six levels in
// tdata and the clip flags plus levels_updated in tuser.
// Config channel: cfg_index_i 0 = hold_ms, 1 = clip_threshold; always ready.
// Sequencing: a frame is squared bit-serially; a frame that does not end
// a block has its result loaded into the output register after the
// squaring. A block end adds up to nine divisions on the shared divider
// plus up to two 16-step square roots before the result is loaded.
// One frame is in flight at a time; the next frame is taken once the
// previous result sits in the output register, even if it is not yet taken.
// If the receiver stalls, the following result waits in the last step.
// Reset clears all meter state and the output valid; registers return to
// hold_ms 2000 and clip_threshold 32000.
module stereo_level_meter_unit import slm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,   // left_sample, right_sample
  input  logic                 s_axis_tlast,
  input  logic                 s_axis_tuser,   // clear_levels
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // peak_l, peak_r, rms_l, rms_r, hold_l, hold_r
  output logic [95:0]          m_axis_tdata,
  output logic [2:0]           m_axis_tuser,   // clip_l, clip_r, levels_updated
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQR   = 3'd1;
  localparam logic [2:0] ST_BEGIN = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_SQRT  = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  localparam logic [3:0] OP_PKL = 4'd0;
  localparam logic [3:0] OP_PKR = 4'd1;
  localparam logic [3:0] OP_HDL = 4'd2;
  localparam logic [3:0] OP_HDR = 4'd3;
  localparam logic [3:0] OP_SQL = 4'd4;
  localparam logic [3:0] OP_SQR = 4'd5;
  localparam logic [3:0] OP_RML = 4'd6;
  localparam logic [3:0] OP_RMR = 4'd7;
  localparam logic [3:0] OP_WIN = 4'd8;

  logic [2:0]  state_q;
  logic [3:0]  op_q;
  logic [15:0] hold_ms_q, clip_thr_q;

  logic [LEVEL_W-1:0] blk_max_q [2];
  logic [SUMSQ_W-1:0] sumsq_q   [2];
  logic [1:0]         blk_clip_q;
  logic [FCNT_W-1:0]  frame_cnt_q;
  logic [LEVEL_W-1:0] peak_q    [2];
  logic [LEVEL_W-1:0] hold_q    [2];
  logic [HCNT_W-1:0]  hold_cnt_q;
  logic [ACC_W-1:0]   acc_q     [2];
  logic [RCNT_W-1:0]  rms_cnt_q;
  logic [LEVEL_W-1:0] rms_q     [2];
  logic [1:0]         sticky_q;
  logic               ended_q, release_q;

  logic [15:0] mag_q  [2];
  logic [15:0] mult_q [2];
  logic [31:0] prod_q [2];
  logic [31:0] prod_d [2];
  logic [3:0]  step_q;

  logic [31:0] sq_x_q;
  logic [17:0] sq_rem_q;
  logic [15:0] sq_root_q;
  logic [19:0] sq_r;
  logic [19:0] sq_trial;
  logic        sq_ge;
  logic [15:0] sq_root_d;

  logic        out_valid_q;
  logic [95:0] out_data_q;
  logic [2:0]  out_user_q;

  div_ctrl_t div_ctrl;
  div_stat_t div_stat;

  logic        accept;
  logic        ch;
  logic [15:0] mag_in [2];
  logic [15:0] lv, pk;
  logic [19:0] attack_num;
  logic [22:0] decay_num;
  logic [FCNT_W-1:0] frame_cnt_new;
  logic        cap0, cap1;
  logic [HCNT_W:0]   hcnt_sum;
  logic [HCNT_W-1:0] hcnt_sat, hold_limit;
  logic [ACC_W-1:0]  quot;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign ch            = op_q[0];
  assign quot          = div_stat.quotient;

  assign mag_in[0] = s_axis_tdata[15]  ? 16'(-s_axis_tdata[15:0])  : s_axis_tdata[15:0];
  assign mag_in[1] = s_axis_tdata[31]  ? 16'(-s_axis_tdata[31:16]) : s_axis_tdata[31:16];
  assign frame_cnt_new = (s_axis_tuser ? '0 : frame_cnt_q) + FCNT_W'(1);

  // per-channel shift-add squaring, MSB of multiplier first
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      prod_d[i] = {prod_q[i][30:0], 1'b0} + (mult_q[i][15] ? 32'(mag_q[i]) : 32'd0);
    end
  end

  // hold capture and release decision
  assign cap0       = blk_max_q[0] > hold_q[0];
  assign cap1       = blk_max_q[1] > hold_q[1];
  assign hcnt_sum   = ((cap0 || cap1) ? (HCNT_W+1)'(0) : {1'b0, hold_cnt_q})
                      + (HCNT_W+1)'(frame_cnt_q);
  assign hcnt_sat   = hcnt_sum[HCNT_W] ? HOLD_CNT_MAX : hcnt_sum[HCNT_W-1:0];
  assign hold_limit = HCNT_W'(hold_ms_q) * HCNT_W'(FS_KHZ);

  // square root step: two radicand bits per cycle
  assign sq_r      = {sq_rem_q, sq_x_q[31:30]};
  assign sq_trial  = {2'b00, sq_root_q, 2'b01};
  assign sq_ge     = sq_r >= sq_trial;
  assign sq_root_d = {sq_root_q[14:0], sq_ge};

  assign lv         = peak_q[ch];
  assign pk         = blk_max_q[ch];
  assign attack_num = ({4'd0, pk} << 1) + {4'd0, pk} + ({4'd0, lv} << 3) - {4'd0, lv};
  assign decay_num  = 23'(lv) * 23'd95;

  always_comb begin
    div_ctrl.start    = (state_q == ST_LOAD);
    div_ctrl.dividend = '0;
    div_ctrl.divisor  = DIVS_W'(1);
    case (op_q)
      OP_PKL, OP_PKR: begin
        if (pk > lv) begin
          div_ctrl.dividend = DIVD_W'(attack_num);
          div_ctrl.divisor  = DIVS_W'(10);
        end else begin
          div_ctrl.dividend = DIVD_W'(decay_num);
          div_ctrl.divisor  = DIVS_W'(100);
        end
      end
      OP_HDL, OP_HDR: begin
        div_ctrl.dividend = DIVD_W'(20'(hold_q[ch]) * 20'd9);
        div_ctrl.divisor  = DIVS_W'(10);
      end
      OP_SQL, OP_SQR: begin
        div_ctrl.dividend = DIVD_W'(sumsq_q[ch]);
        div_ctrl.divisor  = DIVS_W'(frame_cnt_q);
      end
      OP_WIN: begin
        div_ctrl.dividend = DIVD_W'(RMS_WINDOW);
        div_ctrl.divisor  = DIVS_W'(frame_cnt_q);
      end
      OP_RML, OP_RMR: begin
        div_ctrl.dividend = acc_q[ch];
        div_ctrl.divisor  = rms_cnt_q;
      end
      default: ;
    endcase
  end

  slm_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .stat_o (div_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_PKL;
      hold_ms_q   <= HOLD_MS_RESET;
      clip_thr_q  <= CLIP_THR_RESET;
      blk_max_q   <= '{default: '0};
      sumsq_q     <= '{default: '0};
      blk_clip_q  <= '0;
      frame_cnt_q <= '0;
      peak_q      <= '{default: '0};
      hold_q      <= '{default: '0};
      hold_cnt_q  <= '0;
      acc_q       <= '{default: '0};
      rms_cnt_q   <= '0;
      rms_q       <= '{default: '0};
      sticky_q    <= '0;
      ended_q     <= 1'b0;
      release_q   <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_HOLD_MS)  hold_ms_q  <= cfg_data_i;
        if (cfg_index_i == REG_CLIP_THR) clip_thr_q <= cfg_data_i;
      end
      if (state_q == ST_FIN && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (s_axis_tuser) begin
              peak_q     <= '{default: '0};
              hold_q     <= '{default: '0};
              hold_cnt_q <= '0;
              acc_q      <= '{default: '0};
              rms_cnt_q  <= '0;
              rms_q      <= '{default: '0};
              sticky_q   <= '0;
              sumsq_q    <= '{default: '0};
            end
            for (int i = 0; i < 2; i++) begin
              if (s_axis_tuser || mag_in[i] > blk_max_q[i]) begin
                blk_max_q[i] <= (s_axis_tuser || mag_in[i] > blk_max_q[i]) &&
                                mag_in[i] > (s_axis_tuser ? 16'd0 : blk_max_q[i])
                                ? mag_in[i] : 16'd0;
              end
            end
            blk_clip_q  <= (s_axis_tuser ? 2'b00 : blk_clip_q) |
                           {mag_in[1] >= clip_thr_q, mag_in[0] >= clip_thr_q};
            frame_cnt_q <= frame_cnt_new;
            ended_q     <= s_axis_tlast || (frame_cnt_new == FCNT_W'(MAX_BLOCK_FRAMES));
            step_q      <= '0;
            state_q     <= ST_SQR;
          end
        end
        ST_SQR: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd15) begin
            for (int i = 0; i < 2; i++) begin
              sumsq_q[i] <= sumsq_q[i] + SUMSQ_W'(prod_d[i]);
            end
            state_q <= ended_q ? ST_BEGIN : ST_FIN;
          end
        end
        ST_BEGIN: begin
          if (cap0) hold_q[0] <= blk_max_q[0];
          if (cap1) hold_q[1] <= blk_max_q[1];
          hold_cnt_q <= hcnt_sat;
          release_q  <= hcnt_sat > hold_limit;
          rms_cnt_q  <= rms_cnt_q + RCNT_W'(1);
          sticky_q   <= sticky_q | blk_clip_q;
          blk_clip_q <= '0;
          op_q       <= OP_PKL;
          state_q    <= ST_LOAD;
        end
        ST_LOAD: state_q <= ST_DIV;
        ST_DIV: begin
          if (div_stat.done) begin
            case (op_q)
              OP_PKL: begin
                peak_q[0] <= quot[15:0];
                op_q      <= OP_PKR;
                state_q   <= ST_LOAD;
              end
              OP_PKR: begin
                peak_q[1] <= quot[15:0];
                op_q      <= release_q ? OP_HDL : OP_SQL;
                state_q   <= ST_LOAD;
              end
              OP_HDL: begin
                hold_q[0] <= quot[15:0];
                op_q      <= OP_HDR;
                state_q   <= ST_LOAD;
              end
              OP_HDR: begin
                hold_q[1] <= quot[15:0];
                op_q      <= OP_SQL;
                state_q   <= ST_LOAD;
              end
              OP_SQL: begin
                acc_q[0] <= acc_q[0] + quot;
                op_q     <= OP_SQR;
                state_q  <= ST_LOAD;
              end
              OP_SQR: begin
                acc_q[1] <= acc_q[1] + quot;
                op_q     <= OP_WIN;
                state_q  <= ST_LOAD;
              end
              OP_WIN: begin
                if (rms_cnt_q >= quot[RCNT_W-1:0]) begin
                  op_q    <= OP_RML;
                  state_q <= ST_LOAD;
                end else begin
                  state_q <= ST_FIN;
                end
              end
              default: begin
                state_q <= ST_SQRT;
              end
            endcase
          end
        end
        ST_SQRT: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd15) begin
            rms_q[ch] <= sq_root_d;
            acc_q[ch] <= '0;
            if (op_q == OP_RML) begin
              op_q    <= OP_RMR;
              state_q <= ST_LOAD;
            end else begin
              rms_cnt_q <= '0;
              state_q   <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (!out_valid_q || m_axis_tready) begin
            if (ended_q) begin
              blk_max_q   <= '{default: '0};
              sumsq_q     <= '{default: '0};
              frame_cnt_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < 2; i++) begin
        mag_q[i]  <= mag_in[i];
        mult_q[i] <= mag_in[i];
        prod_q[i] <= '0;
      end
    end else if (state_q == ST_SQR) begin
      for (int i = 0; i < 2; i++) begin
        mult_q[i] <= {mult_q[i][14:0], 1'b0};
        prod_q[i] <= prod_d[i];
      end
    end
    if (state_q == ST_DIV && div_stat.done) begin
      sq_x_q    <= quot[31:0];
      sq_rem_q  <= '0;
      sq_root_q <= '0;
    end else if (state_q == ST_SQRT) begin
      sq_x_q    <= {sq_x_q[29:0], 2'b00};
      sq_rem_q  <= sq_ge ? 18'(sq_r - sq_trial) : sq_r[17:0];
      sq_root_q <= sq_root_d;
    end
    if (state_q == ST_FIN && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= {hold_q[1], hold_q[0], rms_q[1], rms_q[0], peak_q[1], peak_q[0]};
      out_user_q <= {ended_q, sticky_q[1], sticky_q[0]};
    end
  end

  // step_q wraps to zero after each 16-step pass, so every square root
  // starts from step zero
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

[sv/slm_checker.sv]
// Port-level checker for the stereo level meter, bound to the top level.
module slm_checker import slm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata
);

  // one frame in flight: intake closes right after a beat is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_peak_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:0] <= 16'd32768 && m_axis_tdata[31:16] <= 16'd32768)
    else $error("peak level out of range");

  // output valid is low from the cycle after reset is seen
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind stereo_level_meter_unit slm_checker u_slm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
